FILE: hdl/binary_descriptor_best_match_assert.svh
// Assertion macros for the binary descriptor best-match block.
// Used by bdm_checker.sv; expects signals clk and rst in the including scope.
`ifndef BINARY_DESCRIPTOR_BEST_MATCH_ASSERT_SVH
`define BINARY_DESCRIPTOR_BEST_MATCH_ASSERT_SVH

// Same-cycle implication, off while in reset.
`define BDM_ASSERT_IMPL(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// Next-cycle implication, off while in reset.
`define BDM_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

// Next-cycle implication that also holds across reset.
`define BDM_ASSERT_NEXT_ALWAYS(name, pre, post, msg) \
  name: assert property (@(posedge clk) (pre) |=> (post)) else $error(msg);

`endif

FILE: hdl/bdm_pkg.sv
// Shared types, constants and functions for the binary descriptor best-match block.
// No dependencies; imported by every design module in hdl/ except bdm_checker.
package bdm_pkg;

  localparam int DESC_W    = 256;
  localparam int WORD_W    = 64;
  localparam int NUM_WORDS = DESC_W / WORD_W;
  localparam int ANGLE_W   = 13;
  localparam int DIST_W    = 9;
  localparam int CNT_W     = 7;
  localparam int INDEX_W   = 16;
  localparam int CAND_IDX_W = 16;
  localparam int APB_ADDR_W = 6;
  localparam int APB_DATA_W = 64;

  localparam logic [DIST_W-1:0]  DIST_NONE     = DIST_W'(256);
  localparam logic [ANGLE_W-1:0] ANGLE_LIM_RST = ANGLE_W'(320);
  localparam logic [DIST_W-1:0]  MARGIN_RST    = DIST_W'(50);

  localparam logic [WORD_W-1:0] M1 = 64'h5555_5555_5555_5555;
  localparam logic [WORD_W-1:0] M2 = 64'h3333_3333_3333_3333;
  localparam logic [WORD_W-1:0] M4 = 64'h0F0F_0F0F_0F0F_0F0F;

  typedef enum logic [2:0] {
    REG_QUERY_WORD0 = 3'd0,
    REG_QUERY_WORD1 = 3'd1,
    REG_QUERY_WORD2 = 3'd2,
    REG_QUERY_WORD3 = 3'd3,
    REG_QUERY_ANGLE = 3'd4,
    REG_ANGLE_LIMIT = 3'd5,
    REG_MARGIN      = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [DESC_W-1:0]  query;
    logic [ANGLE_W-1:0] query_angle;
    logic [ANGLE_W-1:0] angle_limit;
    logic [DIST_W-1:0]  margin;
  } cfg_t;

  // One candidate after the popcount stage.
  typedef struct packed {
    logic [NUM_WORDS-1:0][CNT_W-1:0] part;
    logic                            pass;
    logic [INDEX_W-1:0]              idx;
    logic                            last;
  } dist_t;

  function automatic logic [CNT_W-1:0] popcount64(input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] v;
    logic [CNT_W-1:0]  cnt;
    v = w - ((w >> 1) & M1);
    v = (v & M2) + ((v >> 2) & M2);
    v = (v + (v >> 4)) & M4;
    cnt = '0;
    for (int i = 0; i < WORD_W / 8; i++) begin
      cnt = cnt + CNT_W'(v[8*i +: 8]);
    end
    return cnt;
  endfunction

endpackage

FILE: hdl/binary_descriptor_best_match.sv
// Top level of the binary descriptor best-match block.
// Depends on bdm_pkg, bdm_cfg, bdm_dist and bdm_track.
//
// Streams candidate 256-bit binary descriptors against a query descriptor
// held in configuration registers and reports the nearest one by Hamming
// distance. Each candidate whose keypoint angle lies strictly within
// angle_limit of query_angle (plain absolute difference, no wrap at 360
// degrees) updates a running best and second-best distance; a distance
// equal to the best never displaces it. The candidate with last_cand set is
// counted first, then one result transaction goes out and the search state
// clears: match_found is 1 when second minus best strictly exceeds margin,
// match_index is the best candidate's index (0 when not found), and
// match_distance is the best distance (256 when nothing counted).
// Rate: one candidate per clock, sustained while no final candidate holds
// behind an untaken result. The path from accept to match_valid runs through
// the input register, per-word popcount and angle gate into a second
// register, then the four-way sum, best/second update and result
// register. The best/second update is the one loop that closes each cycle.
// Non-final candidates keep flowing while a result waits to be taken; only
// a final candidate holds behind an untaken result.
// Configuration: APB-style, 64-bit data, register i at byte address 8*i,
// pready always high. Write registers only while the block is idle.
module binary_descriptor_best_match (
  input  logic                              clk,
  input  logic                              rst,
  // configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [bdm_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [bdm_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [bdm_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready,
  // candidate channel
  input  logic                              cand_valid,
  output logic                              cand_ready,
  input  logic [bdm_pkg::WORD_W-1:0]        cand_word0,
  input  logic [bdm_pkg::WORD_W-1:0]        cand_word1,
  input  logic [bdm_pkg::WORD_W-1:0]        cand_word2,
  input  logic [bdm_pkg::WORD_W-1:0]        cand_word3,
  input  logic [bdm_pkg::ANGLE_W-1:0]       cand_angle,
  input  logic [bdm_pkg::CAND_IDX_W-1:0]    cand_index,
  input  logic                              last_cand,
  // result channel
  output logic                              match_valid,
  input  logic                              match_ready,
  output logic                              match_found,
  output logic [15:0]                       match_index,
  output logic [bdm_pkg::DIST_W-1:0]        match_distance
);
  import bdm_pkg::*;

  cfg_t               cfg;

  // Input register
  logic               s1_valid;
  logic               s1_ready;
  logic [DESC_W-1:0]  s1_desc;
  logic [ANGLE_W-1:0] s1_angle;
  logic [INDEX_W-1:0] s1_idx;
  logic               s1_last;

  // Popcount register
  dist_t              s1_dist;
  logic               s2_valid;
  logic               s2_ready;
  dist_t              s2_data;
  logic               s2_adv;

  bdm_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Each stage moves when empty or when the stage after it takes its content.
  assign s2_ready   = !s2_valid || s2_adv;
  assign s1_ready   = !s1_valid || s2_ready;
  assign cand_ready = s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= cand_valid;
    end
  end

  // Capture one candidate transaction; the full 16-bit index is kept.
  always_ff @(posedge clk) begin
    if (cand_valid && s1_ready) begin
      s1_desc  <= {cand_word3, cand_word2, cand_word1, cand_word0};
      s1_angle <= cand_angle;
      s1_idx   <= cand_index[INDEX_W-1:0];
      s1_last  <= last_cand;
    end
  end

  bdm_dist u_dist (
    .cfg   (cfg),
    .desc  (s1_desc),
    .angle (s1_angle),
    .idx   (s1_idx),
    .last  (s1_last),
    .res   (s1_dist)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s2_ready) begin
      s2_data <= s1_dist;
    end
  end

  bdm_track u_track (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .in_valid       (s2_valid),
    .in_data        (s2_data),
    .adv            (s2_adv),
    .match_valid    (match_valid),
    .match_ready    (match_ready),
    .match_found    (match_found),
    .match_index    (match_index),
    .match_distance (match_distance)
  );

endmodule

FILE: hdl/bdm_cfg.sv
// APB-style configuration registers: query descriptor, query angle, angle limit, margin.
// Depends on bdm_pkg.
module bdm_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [bdm_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [bdm_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [bdm_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready,
  output bdm_pkg::cfg_t                    cfg
);
  import bdm_pkg::*;

  reg_idx_t sel;
  logic     wr_en;

  assign sel    = reg_idx_t'(paddr[APB_ADDR_W-1:3]);
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.query       <= '0;
      cfg.query_angle <= '0;
      cfg.angle_limit <= ANGLE_LIM_RST;
      cfg.margin      <= MARGIN_RST;
    end else if (wr_en) begin
      case (sel)
        REG_QUERY_WORD0: cfg.query[0*WORD_W +: WORD_W] <= pwdata;
        REG_QUERY_WORD1: cfg.query[1*WORD_W +: WORD_W] <= pwdata;
        REG_QUERY_WORD2: cfg.query[2*WORD_W +: WORD_W] <= pwdata;
        REG_QUERY_WORD3: cfg.query[3*WORD_W +: WORD_W] <= pwdata;
        REG_QUERY_ANGLE: cfg.query_angle <= pwdata[ANGLE_W-1:0];
        REG_ANGLE_LIMIT: cfg.angle_limit <= pwdata[ANGLE_W-1:0];
        REG_MARGIN:      cfg.margin      <= pwdata[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sel)
      REG_QUERY_WORD0: prdata = cfg.query[0*WORD_W +: WORD_W];
      REG_QUERY_WORD1: prdata = cfg.query[1*WORD_W +: WORD_W];
      REG_QUERY_WORD2: prdata = cfg.query[2*WORD_W +: WORD_W];
      REG_QUERY_WORD3: prdata = cfg.query[3*WORD_W +: WORD_W];
      REG_QUERY_ANGLE: prdata = APB_DATA_W'(cfg.query_angle);
      REG_ANGLE_LIMIT: prdata = APB_DATA_W'(cfg.angle_limit);
      REG_MARGIN:      prdata = APB_DATA_W'(cfg.margin);
      default:         prdata = '0;
    endcase
  end

endmodule

FILE: hdl/bdm_dist.sv
// Per-word Hamming popcount of candidate against query, plus the angle gate.
// Combinational; depends on bdm_pkg.
module bdm_dist (
  input  bdm_pkg::cfg_t                        cfg,
  input  logic [bdm_pkg::DESC_W-1:0]           desc,
  input  logic [bdm_pkg::ANGLE_W-1:0]          angle,
  input  logic [bdm_pkg::INDEX_W-1:0]          idx,
  input  logic                                 last,
  output bdm_pkg::dist_t                       res
);
  import bdm_pkg::*;

  logic [DESC_W-1:0]  diff;
  logic [ANGLE_W-1:0] adiff;

  assign diff  = desc ^ cfg.query;
  // Plain absolute difference, no wrap at 360 degrees
  assign adiff = (angle >= cfg.query_angle) ? angle - cfg.query_angle
                                            : cfg.query_angle - angle;

  always_comb begin
    for (int i = 0; i < NUM_WORDS; i++) begin
      res.part[i] = popcount64(diff[i*WORD_W +: WORD_W]);
    end
    res.pass = adiff < cfg.angle_limit;
    res.idx  = idx;
    res.last = last;
  end

endmodule

FILE: hdl/bdm_track.sv
// Best / second-best distance tracker and result register.
// Depends on bdm_pkg.
module bdm_track (
  input  logic                          clk,
  input  logic                          rst,
  input  bdm_pkg::cfg_t                 cfg,
  input  logic                          in_valid,
  input  bdm_pkg::dist_t                in_data,
  output logic                          adv,
  output logic                          match_valid,
  input  logic                          match_ready,
  output logic                          match_found,
  output logic [15:0]                   match_index,
  output logic [bdm_pkg::DIST_W-1:0]    match_distance
);
  import bdm_pkg::*;

  logic [DIST_W-1:0]  best_dist, best_dist_next;
  logic [DIST_W-1:0]  second_dist, second_dist_next;
  logic [INDEX_W-1:0] best_idx, best_idx_next;
  logic [DIST_W-1:0]  cand_dist;
  logic [DIST_W-1:0]  gap;
  logic               found;

  // A non-final candidate makes no result, so it never waits on the output.
  assign adv = in_valid && (!in_data.last || !match_valid || match_ready);

  always_comb begin
    cand_dist = '0;
    for (int i = 0; i < NUM_WORDS; i++) begin
      cand_dist = cand_dist + DIST_W'(in_data.part[i]);
    end
    best_dist_next   = best_dist;
    second_dist_next = second_dist;
    best_idx_next    = best_idx;
    if (in_data.pass) begin
      if (cand_dist < best_dist) begin
        second_dist_next = best_dist;
        best_dist_next   = cand_dist;
        best_idx_next    = in_data.idx;
      end else if (cand_dist < second_dist) begin
        second_dist_next = cand_dist;
      end
    end
    gap   = second_dist_next - best_dist_next;
    found = gap > cfg.margin;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best_dist   <= DIST_NONE;
      second_dist <= DIST_NONE;
      best_idx    <= '0;
    end else if (adv) begin
      if (in_data.last) begin
        best_dist   <= DIST_NONE;
        second_dist <= DIST_NONE;
        best_idx    <= '0;
      end else begin
        best_dist   <= best_dist_next;
        second_dist <= second_dist_next;
        best_idx    <= best_idx_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      match_valid <= 1'b0;
    end else if (adv && in_data.last) begin
      match_valid <= 1'b1;
    end else if (match_ready) begin
      match_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_data.last) begin
      match_found    <= found;
      match_index    <= found ? 16'(best_idx_next) : '0;
      match_distance <= best_dist_next;
    end
  end

endmodule

FILE: hdl/bdm_checker.sv
// Port-level checker for binary_descriptor_best_match, bound to the top level.
// Depends on binary_descriptor_best_match_assert.svh.
`include "binary_descriptor_best_match_assert.svh"

module bdm_checker (
  input logic        clk,
  input logic        rst,
  input logic        match_valid,
  input logic        match_ready,
  input logic        match_found,
  input logic [15:0] match_index,
  input logic [8:0]  match_distance
);

  // A found match needs second - best > margin, so best is below 256.
  `BDM_ASSERT_IMPL(a_found_dist, match_valid && match_found, match_distance != 9'd256, "match found with distance 256")
  // Index is zeroed when nothing is found.
  `BDM_ASSERT_IMPL(a_nofound_idx, match_valid && !match_found, match_index == 16'd0, "index nonzero without a match")
  // A waiting result holds.
  `BDM_ASSERT_NEXT(a_hold, match_valid && !match_ready, match_valid && $stable(match_found) && $stable(match_index) && $stable(match_distance), "result changed while stalled")
  // Reset drops any pending result.
  `BDM_ASSERT_NEXT_ALWAYS(a_rst_idle, rst, !match_valid, "result valid after reset")

endmodule

bind binary_descriptor_best_match bdm_checker u_bdm_checker (
  .clk            (clk),
  .rst            (rst),
  .match_valid    (match_valid),
  .match_ready    (match_ready),
  .match_found    (match_found),
  .match_index    (match_index),
  .match_distance (match_distance)
);
